/* rtl/core/matrix_power_2x2_mod_prime_macros.svh */
// Assertion macros shared by the checker of the 2x2 modular matrix power block.
`ifndef MATRIX_POWER_2X2_MOD_PRIME_MACROS_SVH
`define MATRIX_POWER_2X2_MOD_PRIME_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix power check failed");

// Next-cycle implication, switched off while reset is asserted.
`define MPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix power check failed");

`endif

/* rtl/core/mpm_pkg.sv */
// Shared types, constants and helpers for the 2x2 modular matrix power block.
package mpm_pkg;

  localparam int EXP_BITS_DEF = 32;

  localparam logic [29:0] MOD_P      = 30'd1000000009;
  localparam logic [31:0] MOD_P32    = 32'd1000000009;
  localparam logic [31:0] TWO_MOD_P  = 32'd2000000018;
  // floor(2^61 / MOD_P), used for the quotient estimate.
  localparam logic [31:0] BARRETT_MU = 32'd2305842988;

  typedef struct packed {
    logic [29:0] entry_00;
    logic [29:0] entry_01;
    logic [29:0] entry_10;
    logic [29:0] entry_11;
    logic [31:0] power;
  } in_item_t;

  typedef struct packed {
    logic [29:0] out_00;
    logic [29:0] out_01;
    logic [29:0] out_10;
    logic [29:0] out_11;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic update;
    logic bit_set;
    logic finish;
  } ctrl_t;

  // A 30-bit value lies below twice the modulus, so one subtraction reduces it.
  function automatic logic [29:0] reduce_entry(input logic [29:0] v);
    reduce_entry = (v >= MOD_P) ? v - MOD_P : v;
  endfunction

endpackage

/* rtl/core/mpm_lane.sv */
// One lane: a modular two-term dot product in a multiply and Barrett reduction pipeline.
module mpm_lane
  import mpm_pkg::*;
(
  input  logic        clk,
  input  logic [29:0] a,
  input  logic [29:0] b,
  input  logic [29:0] c,
  input  logic [29:0] d,
  output logic [29:0] res
);

  logic [59:0] p0;
  logic [59:0] p1;
  logic [60:0] sum_r, sum_nxt;
  logic [63:0] q_full;
  logic [31:0] q_r, q_nxt;
  logic [31:0] slo_r, slo_nxt;
  logic [31:0] qm;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] rem1;

  assign p0      = 60'(a) * 60'(b);
  assign p1      = 60'(c) * 60'(d);
  assign sum_nxt = 61'(p0) + 61'(p1);

  // The estimate falls at most two short of the true quotient.
  assign q_full  = 64'(sum_r[60:29]) * 64'(BARRETT_MU);
  assign q_nxt   = q_full[63:32];
  assign slo_nxt = sum_r[31:0];

  // The true remainder is below three times the modulus, so 32 bits suffice.
  assign qm      = q_r * MOD_P32;
  assign rem_nxt = slo_r - qm;

  assign rem1 = (rem_r >= TWO_MOD_P) ? rem_r - TWO_MOD_P : rem_r;
  assign res  = (rem1 >= MOD_P32) ? 30'(rem1 - MOD_P32) : 30'(rem1);

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    q_r   <= q_nxt;
    slo_r <= slo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* rtl/core/mpm_ctrl.sv */
// Sequencer that scans the exponent and paces the lanes.
module mpm_ctrl
  import mpm_pkg::*;
#(
  parameter int EXP_BITS = EXP_BITS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] power,
  output logic        busy,
  output ctrl_t       ctrl
);

  localparam int BIT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [BIT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    exp_nxt     = exp_r;
    ctrl        = '0;
    ctrl.bit_set = exp_r[0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.load   = 1'b1;
          state_nxt   = ST_RUN;
          phase_nxt   = 2'd0;
          bit_cnt_nxt = BIT_W'(EXP_BITS - 1);
          exp_nxt     = EXP_BITS'(power);
        end
      end
      ST_RUN: begin
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          ctrl.update = 1'b1;
          exp_nxt     = exp_r >> 1;
          if (bit_cnt_r == '0) begin
            ctrl.finish = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            bit_cnt_nxt = bit_cnt_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      phase_r   <= 2'd0;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
    exp_r <= exp_nxt;
  end

endmodule

/* rtl/core/matrix_power_2x2_mod_prime.sv */
// Top level of the 2x2 matrix power block modulo the prime 1000000009.
// Usage: drive in_data and raise start; the item is transferred at a rising edge where
// start is high and busy is low. Entries at or above the modulus are reduced first, and
// only the low EXP_BITS bits of the exponent are used.
// The matrix is raised to the power by square-and-multiply from the least significant
// exponent bit. Eight lanes work side by side: four square the base while four multiply
// the accumulator by the base, and the merge stage keeps the products the bit selects.
// Each lane is a multiply and Barrett reduction pipeline.
// out_valid is high for one cycle at the end of each item. busy falls in that same cycle, so
// a new item may be transferred then; no new item is taken while one is in progress.
// The receiver cannot stall: each result is present on out_data in the cycle in which
// out_valid is high, and out_data holds it until the next result.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid; any
// item in progress is abandoned.
module matrix_power_2x2_mod_prime
  import mpm_pkg::*;
#(
  parameter int EXP_BITS = EXP_BITS_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  ctrl_t       ctrl;
  logic [29:0] base_r [4];
  logic [29:0] acc_r  [4];
  logic [29:0] sq_res [4];
  logic [29:0] mul_res [4];
  logic        out_valid_r;
  out_item_t   out_data_r;

  mpm_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .power (in_data.power),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Lane k computes entry (k/2, k%2) of a product X*Y.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    localparam int ROW = k / 2;
    localparam int COL = k % 2;

    mpm_lane u_sq (
      .clk (clk),
      .a   (base_r[2*ROW]),
      .b   (base_r[COL]),
      .c   (base_r[2*ROW+1]),
      .d   (base_r[2+COL]),
      .res (sq_res[k])
    );

    mpm_lane u_mul (
      .clk (clk),
      .a   (acc_r[2*ROW]),
      .b   (base_r[COL]),
      .c   (acc_r[2*ROW+1]),
      .d   (base_r[2+COL]),
      .res (mul_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      base_r[0] <= reduce_entry(in_data.entry_00);
      base_r[1] <= reduce_entry(in_data.entry_01);
      base_r[2] <= reduce_entry(in_data.entry_10);
      base_r[3] <= reduce_entry(in_data.entry_11);
      acc_r[0]  <= 30'd1;
      acc_r[1]  <= 30'd0;
      acc_r[2]  <= 30'd0;
      acc_r[3]  <= 30'd1;
    end else if (ctrl.update) begin
      base_r <= sq_res;
      if (ctrl.bit_set) begin
        acc_r <= mul_res;
      end
    end
    if (ctrl.finish) begin
      if (ctrl.bit_set) begin
        out_data_r <= '{mul_res[0], mul_res[1], mul_res[2], mul_res[3]};
      end else begin
        out_data_r <= '{acc_r[0], acc_r[1], acc_r[2], acc_r[3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/mpm_checker.sv */
// Port-level checker for the 2x2 modular matrix power block, with its bind.
`include "matrix_power_2x2_mod_prime_macros.svh"

module mpm_checker
  import mpm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  logic out_reduced;

  assign out_reduced = (out_data.out_00 < MOD_P) && (out_data.out_01 < MOD_P) &&
                       (out_data.out_10 < MOD_P) && (out_data.out_11 < MOD_P);

  // A transfer always starts work that lasts beyond the next edge.
  `MPM_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)

  // Each item ends with exactly one result strobe, never two in a row.
  `MPM_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)

  // The sequencer leaves its running state in the very cycle that the result is shown.
  `MPM_ASSERT_SAME(a_fall_with_result, clk, rst_n, $fell(busy), out_valid)

  `MPM_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy)

  // Every entry of a result is fully reduced.
  `MPM_ASSERT_SAME(a_result_reduced, clk, rst_n, out_valid, out_reduced)

endmodule

bind matrix_power_2x2_mod_prime mpm_checker u_mpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* tb/matrix_power_2x2_mod_prime_tb.sv */
// Self-checking testbench for the 2x2 matrix power block modulo the prime 1000000009.
module matrix_power_2x2_mod_prime_tb;
  import mpm_pkg::*;

  localparam int LATENCY = 4 * EXP_BITS_DEF + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1600;
  localparam bit [63:0] PRIME = {34'd0, MOD_P};
  localparam logic [29:0] P_M1 = MOD_P - 30'd1;
  localparam logic [29:0] FULL30 = 30'h3FFFFFFF;
  localparam logic [31:0] ALL_POW = 32'hFFFFFFFF;

  typedef bit [3:0][63:0] mat_t;

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  out_item_t expected_powers[$];
  dir_row_t  directed_rows[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  matrix_power_2x2_mod_prime dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic bit [63:0] mod_dot(bit [63:0] a0, bit [63:0] b0, bit [63:0] a1,
                                        bit [63:0] b1);
    return ((a0 * b0) % PRIME + (a1 * b1) % PRIME) % PRIME;
  endfunction

  function automatic mat_t mat_mul_mod(mat_t x, mat_t y);
    mat_t r;
    r[0] = mod_dot(x[0], y[0], x[1], y[2]);
    r[1] = mod_dot(x[0], y[1], x[1], y[3]);
    r[2] = mod_dot(x[2], y[0], x[3], y[2]);
    r[3] = mod_dot(x[2], y[1], x[3], y[3]);
    return r;
  endfunction

  // Square-and-multiply from the least significant exponent bit, starting at the identity.
  function automatic out_item_t predict_matrix_power(in_item_t it);
    mat_t      base;
    mat_t      acc;
    out_item_t res;
    base[0] = {34'd0, it.entry_00} % PRIME;
    base[1] = {34'd0, it.entry_01} % PRIME;
    base[2] = {34'd0, it.entry_10} % PRIME;
    base[3] = {34'd0, it.entry_11} % PRIME;
    acc = '0;
    acc[0] = 64'd1;
    acc[3] = 64'd1;
    for (int i = 0; i < EXP_BITS_DEF; i++) begin
      if (it.power[i]) begin
        acc = mat_mul_mod(acc, base);
      end
      base = mat_mul_mod(base, base);
    end
    res.out_00 = acc[0][29:0];
    res.out_01 = acc[1][29:0];
    res.out_10 = acc[2][29:0];
    res.out_11 = acc[3][29:0];
    return res;
  endfunction

  function automatic dir_row_t mk_row(logic [29:0] a, logic [29:0] b, logic [29:0] c,
                                      logic [29:0] d, logic [31:0] pw, bit known,
                                      logic [29:0] w0, logic [29:0] w1, logic [29:0] w2,
                                      logic [29:0] w3);
    dir_row_t r;
    r.stim = '{entry_00: a, entry_01: b, entry_10: c, entry_11: d, power: pw};
    r.known = known;
    r.want = '{out_00: w0, out_01: w1, out_10: w2, out_11: w3};
    return r;
  endfunction

  function automatic logic [29:0] random_entry();
    case ($urandom_range(0, 9))
      0: return 30'd0;
      1: return P_M1;
      2: return 30'($urandom_range(MOD_P32, 32'h3FFFFFFF));
      3, 4, 5: return 30'($urandom_range(0, 32'(P_M1)));
      default: return 30'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_power();
    case ($urandom_range(0, 9))
      0: return 32'($urandom_range(0, 20));
      1: return 32'd1 << $urandom_range(0, 31);
      2: return ALL_POW;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_matrix_item();
    in_item_t it;
    it.entry_00 = random_entry();
    it.entry_01 = random_entry();
    it.entry_10 = random_entry();
    it.entry_11 = random_entry();
    it.power = random_power();
    return it;
  endfunction

  // Items 400 to 799 of the random part run with the sender never idling.
  function automatic int pick_gap(int n);
    if (n >= 400 && n < 800) begin
      return 0;
    end
    if ($urandom_range(0, 99) < 26) begin
      return $urandom_range(1, 160);
    end
    return 0;
  endfunction

  // Start stays high from the transfer until the next negative edge; busy is high by then.
  task automatic send_matrix(in_item_t it, int gap, bit known, out_item_t want);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= random_matrix_item();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_powers.push_back(known ? want : predict_matrix_power(it));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result with nothing expected: %0d %0d %0d %0d",
                   out_data.out_00, out_data.out_01, out_data.out_10, out_data.out_11);
        end
      end else begin
        out_item_t want;
        want = expected_powers.pop_front();
        if (out_data.out_00 !== want.out_00 || out_data.out_01 !== want.out_01 ||
            out_data.out_10 !== want.out_10 || out_data.out_11 !== want.out_11) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.out_00, want.out_01, want.out_10, want.out_11,
                     out_data.out_00, out_data.out_01, out_data.out_10, out_data.out_11);
          end
        end
      end
    end
  end

  // Counts cycles in which neither an item nor a result is transferred.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;

    // Zero exponent, the extremes of every field, unreduced entries and a few known powers.
    directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(FULL30, FULL30, FULL30, FULL30, 0, 1, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(1, 0, 0, 1, ALL_POW, 1, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 0, 0, ALL_POW, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(MOD_P, MOD_P + 30'd1, FULL30, P_M1, 1, 1,
                                   0, 1, 30'd73741814, P_M1));
    directed_rows.push_back(mk_row(1, 1, 1, 0, 10, 1, 89, 55, 55, 34));
    directed_rows.push_back(mk_row(1, 1, 1, 0, 1, 1, 1, 1, 1, 0));
    directed_rows.push_back(mk_row(P_M1, P_M1, P_M1, P_M1, 1, 1, P_M1, P_M1, P_M1, P_M1));
    directed_rows.push_back(mk_row(P_M1, P_M1, P_M1, P_M1, 2, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(P_M1, P_M1, P_M1, P_M1, ALL_POW, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(FULL30, FULL30, FULL30, FULL30, ALL_POW, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1, 1, 1, 0, 32'h80000000, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1, 1, 1, 0, ALL_POW, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(2, 0, 0, 3, 32'h55555555, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 1, 1, 0, 32'hAAAAAAAA, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(FULL30, 0, 0, FULL30, 2, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(P_M1, 1, 1, P_M1, 31, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_matrix(directed_rows[i].stim, (i % 3 == 2) ? 1 + i * 7 : 0,
                  directed_rows[i].known, directed_rows[i].want);
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 1000) begin
        drain_results();
      end
      send_matrix(random_matrix_item(), pick_gap(n), 1'b0, '0);
    end

    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
